// ===== hdl/hltd_pkg.sv =====
package hltd_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_RECORD   = 2'd0;
    localparam logic [1:0] KIND_TAIL_ERR = 2'd1;
    localparam logic [1:0] KIND_LONG_ERR = 2'd2;

    // Largest record count that a packet may announce.
    localparam int MAX_RECORDS = 32;

    // Configuration register indexes.
    localparam logic [2:0] CFG_HEADER_FIRST     = 3'd0;
    localparam logic [2:0] CFG_HEADER_SECOND    = 3'd1;
    localparam logic [2:0] CFG_TAIL_BEFORE_LAST = 3'd2;
    localparam logic [2:0] CFG_TAIL_LAST        = 3'd3;
    localparam logic [2:0] CFG_OVERHEAD_LEN     = 3'd4;
    localparam logic [2:0] CFG_HANDLER_MASK     = 3'd5;

    // Configuration register set.
    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
        logic [7:0] tail_before_last;
        logic [7:0] tail_last;
        logic [5:0] overhead_len;
        logic [3:0] handler_mask;
    } t_cfg;

    // Work handed from the parser to the emitter.
    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] count;
    } t_job;

    // One result beat.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] msg_code;
        logic [7:0] value_high;
        logic [7:0] value_low;
        logic       handled;
        logic       last;
    } t_result;

endpackage

// ===== hdl/hltd_store.sv =====
module hltd_store #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    output logic [7:0]    o_rdata_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [7:0]    o_rdata_b
);

    logic [7:0] r_mem [DEPTH];

    // One write port and two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== hdl/hltd_job_fifo.sv =====
module hltd_job_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hltd_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output hltd_pkg::t_job o_job,
    output logic          o_empty
);
    import hltd_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_do_push;
    logic       w_do_pop;

    assign o_full    = (r_cnt == 2'd2);
    assign o_empty   = (r_cnt == 2'd0);
    assign o_job     = r_mem[r_rp];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_do_push) begin
                r_wp <= ~r_wp;
            end
            if (w_do_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// ===== hdl/hltd_front.sv =====
module hltd_front #(
    parameter int PACKET_DEPTH = 128,
    parameter int HEADER_BYTES = 3,
    parameter int AW           = 7
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hltd_pkg::t_cfg i_cfg,
    input  logic           i_push,
    input  logic [7:0]     i_rx_byte,
    output logic           o_full,
    input  logic           i_fifo_full,
    input  logic           i_back_busy,
    output logic           o_job_push,
    output hltd_pkg::t_job o_job,
    output logic           o_we,
    output logic [AW-1:0]  o_waddr,
    output logic [7:0]     o_wdata,
    output logic [AW-1:0]  o_raddr,
    input  logic [7:0]     i_rdata
);
    import hltd_pkg::*;

    localparam logic [2:0] S_START   = 3'd0;
    localparam logic [2:0] S_HUNT    = 3'd1;
    localparam logic [2:0] S_COUNT   = 3'd2;
    localparam logic [2:0] S_COLLECT = 3'd3;
    localparam logic [2:0] S_TAIL_A  = 3'd4;
    localparam logic [2:0] S_TAIL_B  = 3'd5;
    localparam logic [2:0] S_TAIL_C  = 3'd6;

    localparam int         LW        = 9;
    localparam int         MIN_EXTRA = HEADER_BYTES + 2;
    localparam logic [LW-1:0] DEPTH_L = LW'(PACKET_DEPTH);

    logic [2:0]    r_state,     n_state;
    logic [7:0]    r_prev,      n_prev;
    logic [AW-1:0] r_pos,       n_pos;
    logic [5:0]    r_count,     n_count;
    logic [AW-1:0] r_tail_addr, n_tail_addr;
    logic          r_last_ok,   n_last_ok;

    logic          w_accept;
    logic [5:0]    w_extra;
    logic [LW-1:0] w_total_new;
    logic [LW-1:0] w_total_cur;
    logic [LW-1:0] w_pos_next;

    // Short overhead lengths are raised so records and tail never overlap.
    assign w_extra = (i_cfg.overhead_len < 6'(MIN_EXTRA)) ? 6'(MIN_EXTRA) :
                     i_cfg.overhead_len;

    // Packet length for the count arriving now and for the held count.
    assign w_total_new = LW'({i_rx_byte[5:0], 1'b0}) + LW'(i_rx_byte[5:0]) + LW'(w_extra);
    assign w_total_cur = LW'({r_count, 1'b0}) + LW'(r_count) + LW'(w_extra);
    assign w_pos_next  = LW'(r_pos) + LW'(1);

    // Stall while the tail is checked, while the job queue is full, and while
    // collecting would overwrite records that the emitter still reads.
    assign o_full = (r_state == S_TAIL_A) || (r_state == S_TAIL_B) ||
                    (r_state == S_TAIL_C) || i_fifo_full ||
                    ((r_state == S_COLLECT) && i_back_busy);
    assign w_accept = i_push && !o_full;

    assign o_waddr = r_pos;
    assign o_wdata = i_rx_byte;

    // Parser state machine. Header and count bytes are never read back, so
    // only the collected bytes go into the store.
    always_comb begin
        n_state     = r_state;
        n_prev      = r_prev;
        n_pos       = r_pos;
        n_count     = r_count;
        n_tail_addr = r_tail_addr;
        n_last_ok   = r_last_ok;
        o_job_push  = 1'b0;
        o_job       = '0;
        o_we        = 1'b0;
        o_raddr     = r_tail_addr;
        case (r_state)
            S_START: begin
                if (w_accept) begin
                    n_prev  = i_rx_byte;
                    n_state = S_HUNT;
                end
            end
            S_HUNT: begin
                if (w_accept) begin
                    if (r_prev == i_cfg.header_first && i_rx_byte == i_cfg.header_second) begin
                        n_state = S_COUNT;
                    end
                    n_prev = i_rx_byte;
                end
            end
            S_COUNT: begin
                if (w_accept) begin
                    if (i_rx_byte > 8'(MAX_RECORDS) || w_total_new > DEPTH_L) begin
                        o_job_push = 1'b1;
                        o_job.kind = KIND_LONG_ERR;
                        n_state    = S_START;
                    end else begin
                        n_count = i_rx_byte[5:0];
                        n_pos   = AW'(3);
                        n_state = S_COLLECT;
                    end
                end
            end
            S_COLLECT: begin
                if (w_accept) begin
                    if (w_total_cur > DEPTH_L) begin
                        o_job_push = 1'b1;
                        o_job.kind = KIND_LONG_ERR;
                        n_state    = S_START;
                    end else begin
                        o_we = 1'b1;
                        if (w_pos_next < w_total_cur) begin
                            n_pos = r_pos + AW'(1);
                        end else begin
                            n_tail_addr = AW'(w_total_cur - LW'(1));
                            n_state     = S_TAIL_A;
                        end
                    end
                end
            end
            S_TAIL_A: begin
                o_raddr = r_tail_addr;
                n_state = S_TAIL_B;
            end
            S_TAIL_B: begin
                n_last_ok = (i_rdata == i_cfg.tail_last);
                o_raddr   = r_tail_addr - AW'(1);
                n_state   = S_TAIL_C;
            end
            S_TAIL_C: begin
                if (!(r_last_ok && i_rdata == i_cfg.tail_before_last)) begin
                    o_job_push = 1'b1;
                    o_job.kind = KIND_TAIL_ERR;
                end else if (r_count != 6'd0) begin
                    o_job_push  = 1'b1;
                    o_job.kind  = KIND_RECORD;
                    o_job.count = r_count;
                end
                n_state = S_START;
            end
            default: begin
                n_state = S_START;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_START;
            r_prev  <= 8'd0;
            r_pos   <= '0;
            r_count <= 6'd0;
        end else begin
            r_state <= n_state;
            r_prev  <= n_prev;
            r_pos   <= n_pos;
            r_count <= n_count;
        end
    end

    // Tail check working registers.
    always_ff @(posedge i_clk) begin
        r_tail_addr <= n_tail_addr;
        r_last_ok   <= n_last_ok;
    end

endmodule

// ===== hdl/hltd_back.sv =====
module hltd_back #(
    parameter int HEADER_BYTES = 3,
    parameter int TABLE_SIZE   = 4,
    parameter int AW           = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [3:0]        i_handler_mask,
    input  logic              i_fifo_empty,
    input  hltd_pkg::t_job    i_job,
    output logic              o_fifo_pop,
    output logic              o_busy,
    output logic [AW-1:0]     o_raddr,
    input  logic [7:0]        i_rdata,
    output logic              o_empty,
    input  logic              i_pop,
    output hltd_pkg::t_result o_result
);
    import hltd_pkg::*;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_A    = 3'd1;
    localparam logic [2:0] B_B    = 3'd2;
    localparam logic [2:0] B_C    = 3'd3;
    localparam logic [2:0] B_D    = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_base,  n_base;
    logic [5:0]    r_left,  n_left;
    logic [7:0]    r_code,  n_code;
    logic [7:0]    r_high,  n_high;
    logic          r_out_valid, n_out_valid;
    t_result       r_out,   n_out;

    logic          w_out_free;
    logic          w_handled;

    assign o_empty    = !r_out_valid;
    assign o_result   = r_out;
    assign o_busy     = (r_state != B_IDLE) || !i_fifo_empty;
    assign w_out_free = !r_out_valid || i_pop;

    // A code has a handler when it is inside the table and its mask bit is set.
    assign w_handled = (r_code < 8'(TABLE_SIZE)) && (r_code[7:2] == 6'd0) &&
                       i_handler_mask[r_code[1:0]];

    // Emitter: three store reads per record, then one result beat; an error job gives one result beat directly.
    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_left      = r_left;
        n_code      = r_code;
        n_high      = r_high;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_fifo_pop  = 1'b0;
        o_raddr     = r_base + AW'(2);
        if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            B_IDLE: begin
                if (!i_fifo_empty && w_out_free) begin
                    o_fifo_pop = 1'b1;
                    if (i_job.kind != KIND_RECORD) begin
                        n_out       = '0;
                        n_out.kind  = i_job.kind;
                        n_out.last  = 1'b1;
                        n_out_valid = 1'b1;
                    end else begin
                        n_base  = AW'(HEADER_BYTES);
                        n_left  = i_job.count;
                        n_state = B_A;
                    end
                end
            end
            B_A: begin
                o_raddr = r_base;
                n_state = B_B;
            end
            B_B: begin
                n_code  = i_rdata;
                o_raddr = r_base + AW'(1);
                n_state = B_C;
            end
            B_C: begin
                n_high  = i_rdata;
                n_state = B_D;
            end
            B_D: begin
                // The read address holds here, so the low byte stays valid
                // while the result register is still occupied.
                if (w_out_free) begin
                    n_out.kind       = KIND_RECORD;
                    n_out.msg_code   = r_code;
                    n_out.value_high = r_high;
                    n_out.value_low  = i_rdata;
                    n_out.handled    = w_handled;
                    n_out.last       = (r_left == 6'd1);
                    n_out_valid      = 1'b1;
                    n_left           = r_left - 6'd1;
                    n_base           = r_base + AW'(3);
                    n_state          = (r_left == 6'd1) ? B_IDLE : B_A;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_left      <= 6'd0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_left      <= n_left;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_code <= n_code;
        r_high <= n_high;
        r_out  <= n_out;
    end

endmodule

// ===== hdl/head_length_tail_packet_deframer_top.sv =====
// Packet deframer for a serial byte stream framed by two header bytes, a
// record count, three-byte records and two tail bytes.
// Input channel: drive i_rx_byte with push high; the beat is taken when full
// is low. Result channel: a result is on o_* while empty is low and is taken
// with pop. Configuration: i_cfg_we writes i_cfg_data into register
// i_cfg_idx; write only while no packet is being emitted.
// The parser takes bytes back to back while full is low. After the final
// byte of a packet the tail check reads the packet store in states S_TAIL_A
// to S_TAIL_C, during which full is high. Each record then needs three reads
// on the emitter's store port plus the result load; an error job loads its
// result directly. Bytes of a new packet are taken while records of the
// previous one drain, until the first byte after the count would be stored,
// where full holds until the emitter is done.
// When pop is low the finished result waits in the output register and the
// emitter holds; error jobs queue in a two-entry job queue.
// Reset clears the parser, the job queue and the output register and sets
// the configuration to its reset values; the packet store is not cleared.
module head_length_tail_packet_deframer_top #(
    parameter int PACKET_DEPTH = 128,
    parameter int HEADER_BYTES = 3,
    parameter int TABLE_SIZE   = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_rx_byte,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_kind,
    output logic [7:0] o_msg_code,
    output logic [7:0] o_value_high,
    output logic [7:0] o_value_low,
    output logic       o_handled,
    output logic       o_last
);
    import hltd_pkg::*;

    localparam int AW = $clog2(PACKET_DEPTH);

    t_cfg          r_cfg;
    t_job          w_push_job;
    t_job          w_pop_job;
    t_result       w_result;
    logic          w_job_push;
    logic          w_job_pop;
    logic          w_fifo_full;
    logic          w_fifo_empty;
    logic          w_back_busy;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [7:0]    w_wdata;
    logic [AW-1:0] w_raddr_a;
    logic [7:0]    w_rdata_a;
    logic [AW-1:0] w_raddr_b;
    logic [7:0]    w_rdata_b;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_first     <= 8'd0;
            r_cfg.header_second    <= 8'd0;
            r_cfg.tail_before_last <= 8'd0;
            r_cfg.tail_last        <= 8'd0;
            r_cfg.overhead_len     <= 6'd5;
            r_cfg.handler_mask     <= 4'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HEADER_FIRST:     r_cfg.header_first     <= i_cfg_data;
                CFG_HEADER_SECOND:    r_cfg.header_second    <= i_cfg_data;
                CFG_TAIL_BEFORE_LAST: r_cfg.tail_before_last <= i_cfg_data;
                CFG_TAIL_LAST:        r_cfg.tail_last        <= i_cfg_data;
                CFG_OVERHEAD_LEN:     r_cfg.overhead_len     <= i_cfg_data[5:0];
                CFG_HANDLER_MASK:     r_cfg.handler_mask     <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // Byte parser.
    hltd_front #(
        .PACKET_DEPTH (PACKET_DEPTH),
        .HEADER_BYTES (HEADER_BYTES),
        .AW           (AW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_push      (push),
        .i_rx_byte   (i_rx_byte),
        .o_full      (full),
        .i_fifo_full (w_fifo_full),
        .i_back_busy (w_back_busy),
        .o_job_push  (w_job_push),
        .o_job       (w_push_job),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr_a),
        .i_rdata     (w_rdata_a)
    );

    // Packet store shared by parser and emitter.
    hltd_store #(
        .DEPTH (PACKET_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_rdata_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_b (w_rdata_b)
    );

    // Job queue between parser and emitter.
    hltd_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_push_job),
        .o_full  (w_fifo_full),
        .i_pop   (w_job_pop),
        .o_job   (w_pop_job),
        .o_empty (w_fifo_empty)
    );

    // Result emitter.
    hltd_back #(
        .HEADER_BYTES (HEADER_BYTES),
        .TABLE_SIZE   (TABLE_SIZE),
        .AW           (AW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_handler_mask (r_cfg.handler_mask),
        .i_fifo_empty   (w_fifo_empty),
        .i_job          (w_pop_job),
        .o_fifo_pop     (w_job_pop),
        .o_busy         (w_back_busy),
        .o_raddr        (w_raddr_b),
        .i_rdata        (w_rdata_b),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_result       (w_result)
    );

    assign o_kind       = w_result.kind;
    assign o_msg_code   = w_result.msg_code;
    assign o_value_high = w_result.value_high;
    assign o_value_low  = w_result.value_low;
    assign o_handled    = w_result.handled;
    assign o_last       = w_result.last;

endmodule

// ===== tb/head_length_tail_packet_deframer_top_test.sv =====
`timescale 1ns / 1ps

module head_length_tail_packet_deframer_top_test;
    import hltd_pkg::*;

    localparam int PACKET_DEPTH  = 128;
    localparam int HEADER_BYTES  = 3;
    localparam int TABLE_SIZE    = 4;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_BEATS  = 280;
    localparam int PHASE_BEATS   = 40;

    // Parser phases of the predictor.
    typedef enum logic [1:0] {
        HUNT_FRESH,
        HUNT_WINDOW,
        READ_COUNT,
        COLLECT
    } t_parse_phase;

    // One pending input beat with the idle gap that comes before it.
    typedef struct {
        logic [7:0]  value;
        int unsigned gap;
        bit          settle;
    } t_rx_beat;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic [2:0] i_cfg_idx  = CFG_HEADER_FIRST;
    logic [7:0] i_cfg_data = 8'd0;
    logic       push       = 1'b0;
    logic [7:0] i_rx_byte  = 8'd0;
    logic       pop        = 1'b0;
    logic       full;
    logic       empty;
    logic [1:0] o_kind;
    logic [7:0] o_msg_code;
    logic [7:0] o_value_high;
    logic [7:0] o_value_low;
    logic       o_handled;
    logic       o_last;

    head_length_tail_packet_deframer_top #(
        .PACKET_DEPTH(PACKET_DEPTH),
        .HEADER_BYTES(HEADER_BYTES),
        .TABLE_SIZE  (TABLE_SIZE)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_rx_byte   (i_rx_byte),
        .empty       (empty),
        .pop         (pop),
        .o_kind      (o_kind),
        .o_msg_code  (o_msg_code),
        .o_value_high(o_value_high),
        .o_value_low (o_value_low),
        .o_handled   (o_handled),
        .o_last      (o_last)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state: register shadow, parser and packet bytes.
    t_cfg         shadow_cfg;
    t_parse_phase parse_phase = HUNT_FRESH;
    logic [7:0]   prev_byte   = 8'd0;
    logic [7:0]   byte_pos    = 8'd0;
    logic [5:0]   rec_count   = 6'd0;
    logic [7:0]   pkt_bytes [PACKET_DEPTH];
    t_result      awaited_results [$];

    // Stimulus and bookkeeping.
    t_rx_beat    pending_beats [$];
    logic        rx_taken    = 1'b0;
    bit          beat_armed  = 1'b0;
    int unsigned gap_left    = 0;
    int unsigned pop_hold    = 0;
    bit          calm        = 1'b0;
    int unsigned beats_queued = 0;
    int unsigned beats_taken = 0;
    int unsigned results_seen = 0;
    int unsigned error_results = 0;
    int unsigned mismatches  = 0;
    int unsigned cfg_sets    = 0;
    int unsigned cycle_count = 0;
    logic [7:0]  opening_bytes [24];

    // Idle gap length: mostly none, some short, a few long.
    function automatic int unsigned idle_gap();
        int unsigned roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Packet length for the current record count, with the short tail clamp.
    function automatic int unsigned frame_length();
        int unsigned extra;
        extra = shadow_cfg.overhead_len;
        if (extra < HEADER_BYTES + 2) extra = HEADER_BYTES + 2;
        return int'(rec_count) * 3 + extra;
    endfunction

    function automatic logic [7:0] stored_at(input int unsigned idx);
        return (idx < PACKET_DEPTH) ? pkt_bytes[idx] : 8'd0;
    endfunction

    // An error result ends the packet and restarts the hunt.
    task automatic queue_error(input logic [1:0] kind);
        t_result r;
        r.kind       = kind;
        r.msg_code   = 8'd0;
        r.value_high = 8'd0;
        r.value_low  = 8'd0;
        r.handled    = 1'b0;
        r.last       = 1'b1;
        awaited_results.push_back(r);
        parse_phase = HUNT_FRESH;
        byte_pos    = 8'd0;
    endtask

    // Advance the predicted parser by one received byte.
    task automatic deframe_byte(input logic [7:0] b);
        int unsigned total;
        int unsigned base;
        int unsigned n;
        t_result     r;
        case (parse_phase)
            HUNT_FRESH: begin
                prev_byte   = b;
                parse_phase = HUNT_WINDOW;
            end
            HUNT_WINDOW: begin
                if (prev_byte == shadow_cfg.header_first && b == shadow_cfg.header_second) begin
                    pkt_bytes[0] = prev_byte;
                    pkt_bytes[1] = b;
                    byte_pos     = 8'd2;
                    parse_phase  = READ_COUNT;
                end
                prev_byte = b;
            end
            READ_COUNT: begin
                if (b > MAX_RECORDS) begin
                    queue_error(KIND_LONG_ERR);
                end else begin
                    rec_count = b[5:0];
                    if (frame_length() > PACKET_DEPTH) begin
                        queue_error(KIND_LONG_ERR);
                    end else begin
                        pkt_bytes[2] = b;
                        byte_pos     = 8'd3;
                        parse_phase  = COLLECT;
                    end
                end
            end
            default: begin
                // The length is rechecked on every byte since the overhead
                // length may change while a packet is collected.
                total = frame_length();
                if (total > PACKET_DEPTH) begin
                    queue_error(KIND_LONG_ERR);
                end else begin
                    if (byte_pos < PACKET_DEPTH) pkt_bytes[byte_pos] = b;
                    if (byte_pos + 1 < total) begin
                        byte_pos = byte_pos + 8'd1;
                    end else if (stored_at(total - 1) != shadow_cfg.tail_last ||
                                 stored_at(total - 2) != shadow_cfg.tail_before_last) begin
                        queue_error(KIND_TAIL_ERR);
                    end else begin
                        for (n = 0; n < rec_count; n++) begin
                            base         = HEADER_BYTES + 3 * n;
                            r.kind       = KIND_RECORD;
                            r.msg_code   = stored_at(base);
                            r.value_high = stored_at(base + 1);
                            r.value_low  = stored_at(base + 2);
                            r.handled    = (r.msg_code < TABLE_SIZE && r.msg_code < 4) ?
                                           shadow_cfg.handler_mask[r.msg_code[1:0]] : 1'b0;
                            r.last       = (n + 1 == rec_count);
                            awaited_results.push_back(r);
                        end
                        parse_phase = HUNT_FRESH;
                        byte_pos    = 8'd0;
                    end
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input bit orphan, input t_result want, input t_result got);
        mismatches++;
        if (mismatches <= 10) begin
            if (orphan) begin
                $display("[%0t] result with nothing awaited: kind=%0d code=%h hi=%h lo=%h h=%b l=%b",
                         $time, got.kind, got.msg_code, got.value_high, got.value_low,
                         got.handled, got.last);
            end else begin
                $display("[%0t] mismatch: want kind=%0d code=%h hi=%h lo=%h h=%b l=%b",
                         $time, want.kind, want.msg_code, want.value_high, want.value_low,
                         want.handled, want.last);
                $display("            got  kind=%0d code=%h hi=%h lo=%h h=%b l=%b",
                         got.kind, got.msg_code, got.value_high, got.value_low,
                         got.handled, got.last);
            end
        end
    endtask

    // Monitor: results are checked against the oldest expectation, then an
    // accepted input beat advances the predictor.
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results awaited",
                     cycle_count, awaited_results.size());
            $display("Regression FAIL");
            $finish;
        end else begin
            rx_taken <= i_rst_n && push && !full;
            if (i_rst_n) begin
                if (pop && !empty) begin
                    got.kind       = o_kind;
                    got.msg_code   = o_msg_code;
                    got.value_high = o_value_high;
                    got.value_low  = o_value_low;
                    got.handled    = o_handled;
                    got.last       = o_last;
                    results_seen++;
                    if (got.kind != KIND_RECORD) error_results++;
                    if (awaited_results.size() == 0) begin
                        report_mismatch(1'b1, got, got);
                    end else begin
                        want = awaited_results.pop_front();
                        if (got.kind !== want.kind || got.msg_code !== want.msg_code ||
                            got.value_high !== want.value_high ||
                            got.value_low !== want.value_low ||
                            got.handled !== want.handled || got.last !== want.last)
                            report_mismatch(1'b0, want, got);
                    end
                end
                if (push && !full) begin
                    beats_taken++;
                    deframe_byte(i_rx_byte);
                end
            end
        end
    end

    // Driver: presents pending beats, holding each until it is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || rx_taken) begin
            if (pending_beats.size() != 0 && !beat_armed) begin
                gap_left   = pending_beats[0].gap;
                beat_armed = 1'b1;
            end
            if (pending_beats.size() == 0) begin
                push <= 1'b0;
            end else if (gap_left != 0) begin
                gap_left--;
                push <= 1'b0;
            end else if (pending_beats[0].settle && awaited_results.size() != 0) begin
                // Hold the sender until every awaited result has drained.
                push <= 1'b0;
            end else begin
                i_rx_byte <= pending_beats[0].value;
                push      <= 1'b1;
                pending_beats.delete(0);
                beat_armed = 1'b0;
            end
        end
    end

    // Result side stalls at random.
    always @(negedge i_clk) begin
        if (pop_hold != 0) begin
            pop_hold--;
            pop <= 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            pop_hold = idle_gap();
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    task automatic add_beat(input logic [7:0] value, input bit settle);
        t_rx_beat beat;
        beat.value  = value;
        beat.gap    = idle_gap();
        beat.settle = settle;
        pending_beats.push_back(beat);
        beats_queued++;
    endtask

    // Queue one packet for the current settings; a count above the limit
    // stops after the count byte, a bad tail corrupts one or both tail bytes.
    task automatic queue_packet(input logic [7:0] count, input bit bad_tail, input bit settle);
        int unsigned extra;
        int unsigned k;
        logic [7:0]  code;
        logic [7:0]  tail_a;
        logic [7:0]  tail_b;
        extra = shadow_cfg.overhead_len;
        if (extra < HEADER_BYTES + 2) extra = HEADER_BYTES + 2;
        add_beat(shadow_cfg.header_first, settle);
        add_beat(shadow_cfg.header_second, 1'b0);
        add_beat(count, 1'b0);
        if (count > MAX_RECORDS) return;
        for (k = 0; k < count; k++) begin
            code = $urandom_range(0, 1) ? 8'($urandom_range(0, 5)) : 8'($urandom);
            add_beat(code, 1'b0);
            add_beat(8'($urandom), 1'b0);
            add_beat(8'($urandom), 1'b0);
        end
        for (k = HEADER_BYTES + 2; k < extra; k++) add_beat(8'($urandom), 1'b0);
        tail_a = shadow_cfg.tail_before_last;
        tail_b = shadow_cfg.tail_last;
        if (bad_tail) begin
            case ($urandom_range(0, 2))
                0: tail_a = tail_a ^ 8'($urandom_range(1, 255));
                1: tail_b = tail_b ^ 8'($urandom_range(1, 255));
                default: begin
                    tail_a = tail_a ^ 8'($urandom_range(1, 255));
                    tail_b = tail_b ^ 8'($urandom_range(1, 255));
                end
            endcase
        end
        add_beat(tail_a, 1'b0);
        add_beat(tail_b, 1'b0);
    endtask

    // Record counts: mostly small, now and then the largest.
    function automatic logic [7:0] pick_count();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 15) return 8'd0;
        if (roll < 80) return 8'($urandom_range(1, 4));
        if (roll < 95) return 8'($urandom_range(5, 10));
        return 8'(MAX_RECORDS);
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            CFG_HEADER_FIRST:     shadow_cfg.header_first     = value;
            CFG_HEADER_SECOND:    shadow_cfg.header_second    = value;
            CFG_TAIL_BEFORE_LAST: shadow_cfg.tail_before_last = value;
            CFG_TAIL_LAST:        shadow_cfg.tail_last        = value;
            CFG_OVERHEAD_LEN:     shadow_cfg.overhead_len     = value[5:0];
            CFG_HANDLER_MASK:     shadow_cfg.handler_mask     = value[3:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input t_cfg c);
        write_reg(CFG_HEADER_FIRST, c.header_first);
        write_reg(CFG_HEADER_SECOND, c.header_second);
        write_reg(CFG_TAIL_BEFORE_LAST, c.tail_before_last);
        write_reg(CFG_TAIL_LAST, c.tail_last);
        write_reg(CFG_OVERHEAD_LEN, {2'b00, c.overhead_len});
        write_reg(CFG_HANDLER_MASK, {4'b0000, c.handler_mask});
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_sets++;
    endtask

    // Wait until all beats are taken and all results have come, then give
    // the block time to finish a packet that causes no result.
    task automatic drain();
        while (pending_beats.size() != 0 || push) @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_cfg        cfg;
        int unsigned beats_goal;
        int unsigned phase_end;
        int unsigned phase_no;
        int unsigned roll;
        bit          first;

        shadow_cfg = '{8'd0, 8'd0, 8'd0, 8'd0, 6'd5, 4'd1};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: two records with codes at and past the handler
        // table, a zero-count packet, an oversized count and a bad tail.
        program_regs('{8'hFF, 8'h00, 8'h00, 8'hFF, 6'd5, 4'hF});
        opening_bytes = '{8'hFF, 8'h00, 8'h02, 8'h03, 8'hAA, 8'h55, 8'h04, 8'h00,
                          8'hFF, 8'h00, 8'hFF,
                          8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF,
                          8'hFF, 8'h00, 8'h21,
                          8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF};
        foreach (opening_bytes[k]) add_beat(opening_bytes[k], k == 16);
        drain();

        // Random part: one register setting per phase, extremes first.
        beats_goal = beats_queued + RANDOM_BEATS;
        phase_no   = 0;
        while (beats_queued < beats_goal) begin
            if (phase_no == 0) begin
                cfg = '{8'h00, 8'h00, 8'h00, 8'h00, 6'd5, 4'h0};
            end else if (phase_no == 1) begin
                cfg = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 6'd32, 4'hF};
            end else begin
                cfg.header_first     = 8'($urandom);
                cfg.header_second    = 8'($urandom);
                cfg.tail_before_last = 8'($urandom);
                cfg.tail_last        = 8'($urandom);
                cfg.overhead_len     = $urandom_range(0, 3) == 0 ?
                                       6'($urandom_range(5, 32)) : 6'($urandom_range(5, 9));
                cfg.handler_mask     = 4'($urandom);
            end
            program_regs(cfg);
            calm      = (phase_no % 4 == 3);
            phase_end = beats_queued + PHASE_BEATS;
            first     = 1'b1;
            while (beats_queued < phase_end) begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    queue_packet(pick_count(), 1'b0,
                                 first && (phase_no == 0 || $urandom_range(0, 2) == 0));
                end else if (roll < 80) begin
                    queue_packet(pick_count(), 1'b1, 1'b0);
                end else if (roll < 88) begin
                    queue_packet(8'($urandom_range(MAX_RECORDS + 1, 255)), 1'b0, 1'b0);
                end else begin
                    repeat ($urandom_range(1, 4)) add_beat(8'($urandom), 1'b0);
                end
                first = 1'b0;
            end
            // Leave a packet half collected so the next setting lands mid-packet.
            if (phase_no % 3 == 1) begin
                add_beat(shadow_cfg.header_first, 1'b0);
                add_beat(shadow_cfg.header_second, 1'b0);
                add_beat(8'($urandom_range(0, 6)), 1'b0);
                repeat ($urandom_range(1, 4)) add_beat(8'($urandom), 1'b0);
            end
            drain();
            phase_no++;
        end
        calm = 1'b0;

        $display("Ran %0d input beats and %0d results (%0d of them errors) under %0d settings.",
                 beats_taken, results_seen, error_results, cfg_sets);
        $display("Mismatches: %0d, results still awaited: %0d.",
                 mismatches, awaited_results.size());
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
